// ----- design/sliding_window_mean_stddev_macros.svh -----
// Assertion macros for the sliding window mean / deviation block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef SLIDING_WINDOW_MEAN_STDDEV_MACROS_SVH
`define SLIDING_WINDOW_MEAN_STDDEV_MACROS_SVH

// Checked only outside reset.
`define SWMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SWMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/swms_pkg.sv -----
// Package for the sliding window mean / deviation block.
// Payload structs, register and operation codes, fixed widths. No dependencies.
`default_nettype none
package swms_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned SQ_W       = 2 * SAMPLE_W;
  localparam int unsigned ROOT_W     = SQ_W / 2;
  localparam int unsigned WL_W       = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // largest positive value, used when the deviation saturates
  localparam logic [SAMPLE_W-1:0] VALUE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 2'd1;

  // operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // mode codes
  localparam logic MODE_MEAN = 1'b0;
  localparam logic MODE_DEV  = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       divide_fault;
  } out_t;

endpackage
`default_nettype wire

// ----- design/swms_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; shared by the mean and variance divisions.
`default_nettype none
module swms_div #(
  parameter int unsigned DW = 70,
  parameter int unsigned VW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d, div_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [VW:0]   rem_sh;
  logic          fits;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    fits   = rem_sh >= {1'b0, div_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? VW'(rem_sh - {1'b0, div_q}) : rem_sh[VW-1:0];
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) div_q <= divisor_i;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

// ----- design/swms_sqrt.sv -----
// Iterative floor square root, one result bit per cycle.
// Uses swms_pkg for the operand width.
`default_nettype none
module swms_sqrt
  import swms_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SQ_W-1:0]   radicand_i,
  output logic                   done_o,
  output logic [ROOT_W-1:0]      root_o
);
  logic [SQ_W-1:0] v_q, v_d, res_q, res_d, bit_q, bit_d, trial;
  logic            busy_q, busy_d, done_q, done_d;

  always_comb begin
    trial  = res_q + bit_q;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = radicand_i;
      res_d  = '0;
      bit_d  = SQ_W'(1) << (SQ_W - 2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      // last pass handles the lowest bit
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];
endmodule
`default_nettype wire

// ----- design/sliding_window_mean_stddev.sv -----
// Top level: sliding window mean / sample standard deviation.
// Uses swms_pkg, swms_div, swms_sqrt and the assertion macro header.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------
//  cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//  in       | in_valid_i / in_ready_o   | in_data_i (op, sample)
//  out      | out_valid_o / out_ready_i | out_data_o (value, divide_fault)
//
// Clear empties the window and gives no result. Mean: one division per transaction, on the bit-serial divider.
// Deviation: adds, per held sample, the steps ring read, subtract, square and
// accumulate, then the second division and the square root.
// Reset is asynchronous, active low; the ring needs no clearing pass.
// A result waits in the output register; the next input is taken meanwhile.
`default_nettype none
`include "sliding_window_mean_stddev_macros.svh"
module sliding_window_mean_stddev
  import swms_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_t                       out_data_o
);
  localparam int unsigned IDX_W = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_W = SAMPLE_W + IDX_W + 1;
  localparam int unsigned DIV_W = SQ_W + IDX_W + 1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_UPD   = 13'b0000000000010,
    S_MDIV  = 13'b0000000000100,
    S_MWAIT = 13'b0000000001000,
    S_RD    = 13'b0000000010000,
    S_MAG   = 13'b0000000100000,
    S_MUL   = 13'b0000001000000,
    S_ACC   = 13'b0000010000000,
    S_VDIV  = 13'b0000100000000,
    S_VWAIT = 13'b0001000000000,
    S_SQRT  = 13'b0010000000000,
    S_SWAIT = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [WL_W-1:0] wl_q;
  logic            mode_q;

  // window state
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] oldest_q, oldest_d;
  logic [SUM_W-1:0] sum_q, sum_d;

  // work registers
  logic signed [SAMPLE_W-1:0] x_q, mean_q, mean_d, res_val_q, res_val_d;
  logic                       res_fault_q, res_fault_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [SAMPLE_W-1:0]        mag_q;
  logic [SQ_W-1:0]            prod_q;
  logic [DIV_W-1:0]           acc_q, acc_d;
  out_t                       out_q;
  logic                       out_valid_q;

  // ring memory
  logic signed [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic [IDX_W-1:0]           raddr, wpos;
  logic                       wr_en;

  // divider, shared by both divisions, and square root unit
  logic             div_start, div_done, sqrt_start, sqrt_done;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [CNT_W-1:0] div_divisor;
  logic [ROOT_W-1:0] root;

  // misc combinational
  logic [31:0]           len_w;
  logic [CNT_W-1:0]      len;
  logic                  evict;
  logic [CNT_W-1:0]      fill_ev;
  logic [IDX_W-1:0]      oldest_ev;
  logic [IDX_W:0]        pos_raw;
  logic [SUM_W-1:0]      sum_abs;
  logic                  sum_neg_q;
  logic signed [SAMPLE_W:0] diff;
  logic                  out_free;

  // effective window length
  always_comb begin
    if (wl_q == '0) len_w = 32'd1;
    else if (32'(wl_q) > WINDOW_MAX) len_w = WINDOW_MAX;
    else len_w = 32'(wl_q);
    len = len_w[CNT_W-1:0];
  end

  // configuration writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= WL_W'(8);
      mode_q <= MODE_MEAN;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LENGTH: wl_q   <= cfg_data_i[WL_W-1:0];
        CFG_MODE:          mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // eviction and write position
  always_comb begin
    evict     = fill_q >= len;
    fill_ev   = evict ? fill_q - 1'b1 : fill_q;
    oldest_ev = oldest_q;
    if (evict) begin
      oldest_ev = (({1'b0, oldest_q} + 1'b1) == (IDX_W+1)'(WINDOW_MAX))
                  ? '0 : oldest_q + 1'b1;
    end
    pos_raw = {1'b0, oldest_ev} + fill_ev[IDX_W:0];
    if (pos_raw >= (IDX_W+1)'(WINDOW_MAX)) pos_raw = pos_raw - (IDX_W+1)'(WINDOW_MAX);
    wpos = pos_raw[IDX_W-1:0];
  end

  assign raddr   = (state_q == S_IDLE) ? oldest_q : idx_q;
  assign wr_en   = (state_q == S_UPD);
  assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : sum_q;
  assign diff    = (SAMPLE_W+1)'(rd_q) - (SAMPLE_W+1)'(mean_q);
  assign out_free = !out_valid_q || out_ready_i;

  // ring memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) ring_mem[wpos] <= x_q;
    rd_q <= ring_mem[raddr];
  end

  // shared unit hookup
  assign div_start    = (state_q == S_MDIV) || (state_q == S_VDIV);
  assign div_dividend = (state_q == S_MDIV) ? DIV_W'(sum_abs) : acc_q;
  assign div_divisor  = (state_q == S_MDIV) ? fill_q : len - 1'b1;
  assign sqrt_start   = (state_q == S_SQRT);

  swms_div #(.DW(DIV_W), .VW(CNT_W)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_dividend), .divisor_i(div_divisor),
    .done_o(div_done), .quotient_o(div_quo)
  );

  swms_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i(sqrt_start), .radicand_i(div_quo[SQ_W-1:0]),
    .done_o(sqrt_done), .root_o(root)
  );

  assign in_ready_o = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    oldest_d    = oldest_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    res_val_d   = res_val_q;
    res_fault_d = res_fault_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.op == OP_CLEAR) begin
            fill_d   = '0;
            oldest_d = '0;
            sum_d    = '0;
          end else begin
            state_d = S_UPD;
          end
        end
      end
      S_UPD: begin
        sum_d    = sum_q - (evict ? SUM_W'(rd_q) : '0) + SUM_W'(x_q);
        fill_d   = fill_ev + 1'b1;
        oldest_d = oldest_ev;
        state_d  = S_MDIV;
      end
      S_MDIV: state_d = S_MWAIT;
      S_MWAIT: begin
        if (div_done) begin
          mean_d = sum_neg_q ? SAMPLE_W'(-div_quo[SAMPLE_W-1:0])
                             : div_quo[SAMPLE_W-1:0];
          if (mode_q == MODE_MEAN) begin
            res_val_d   = mean_d;
            res_fault_d = 1'b0;
            state_d     = S_FIN;
          end else if (len == CNT_W'(1)) begin
            res_val_d   = '0;
            res_fault_d = 1'b1;
            state_d     = S_FIN;
          end else begin
            res_fault_d = 1'b0;
            idx_d       = oldest_q;
            cnt_d       = '0;
            acc_d       = '0;
            state_d     = S_RD;
          end
        end
      end
      S_RD:  state_d = S_MAG;
      S_MAG: state_d = S_MUL;
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        acc_d = acc_q + DIV_W'(prod_q);
        idx_d = (({1'b0, idx_q} + 1'b1) == (IDX_W+1)'(WINDOW_MAX)) ? '0 : idx_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
        state_d = (cnt_q + 1'b1 == fill_q) ? S_VDIV : S_RD;
      end
      S_VDIV: state_d = S_VWAIT;
      S_VWAIT: begin
        if (div_done) begin
          // variance at or above 2^62 saturates the root
          if (div_quo[DIV_W-1:SQ_W-2] != '0) begin
            res_val_d = VALUE_MAX;
            state_d   = S_FIN;
          end else begin
            state_d = S_SQRT;
          end
        end
      end
      S_SQRT: state_d = S_SWAIT;
      S_SWAIT: begin
        if (sqrt_done) begin
          res_val_d = root[SAMPLE_W-1:0];
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      oldest_q    <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      sum_q    <= sum_d;
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) x_q <= in_data_i.sample;
    if (state_q == S_MDIV) sum_neg_q <= sum_q[SUM_W-1];
    mean_q      <= mean_d;
    res_val_q   <= res_val_d;
    res_fault_q <= res_fault_d;
    idx_q       <= idx_d;
    cnt_q       <= cnt_d;
    acc_q       <= acc_d;
    mag_q       <= diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    prod_q      <= SQ_W'(mag_q) * SQ_W'(mag_q);
    if (state_q == S_FIN && out_free) begin
      out_q.value        <= res_val_q;
      out_q.divide_fault <= res_fault_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `SWMS_ASSERT(a_fill_bound, fill_q <= CNT_W'(WINDOW_MAX), "fill count above ring depth")
  `SWMS_ASSERT(a_out_from_fin, $rose(out_valid_o) |-> $past(state_q) == S_FIN,
               "result raised outside finish step")
  `SWMS_ASSERT(a_fault_zero, out_valid_o && out_data_o.divide_fault |-> out_data_o.value == '0,
               "divide fault with nonzero value")
  `SWMS_ASSERT_ALWAYS(a_ready_idle, in_ready_o |-> state_q == S_IDLE || !rst_ni,
                      "input ready while busy")
endmodule
`default_nettype wire
